>>> hw/rtl/rop_pkg.sv
// Package for the overlay pixel-pair packer: payload structs, format codes,
// colour coefficients, the per-lane result type and pipe control. No dependencies.
package rop_pkg;

    localparam int unsigned PIX_W = 32;
    localparam int unsigned FMT_W = 3;

    localparam logic [FMT_W-1:0] FMT_PASS32 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_YUY2   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_UYVY   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGB555 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd4;

    localparam logic [16:0] Y_R_COEF = 17'd74;
    localparam logic [16:0] Y_G_COEF = 17'd151;
    localparam logic [16:0] Y_B_COEF = 17'd36;
    localparam logic [15:0] U_R_COEF = 16'd36;
    localparam logic [15:0] U_G_COEF = 16'd74;
    localparam logic [15:0] U_B_COEF = 16'd110;
    localparam logic [15:0] V_R_COEF = 16'd92;
    localparam logic [15:0] V_G_COEF = 16'd74;
    localparam logic [15:0] V_B_COEF = 16'd18;
    localparam logic [15:0] CHROMA_OFS = 16'd32768;

    typedef struct packed {
        logic [PIX_W-1:0] first_pixel;
        logic [PIX_W-1:0] second_pixel;
    } t_in_req;

    typedef struct packed {
        logic [PIX_W-1:0] low_word;
        logic [PIX_W-1:0] high_word;
        logic [1:0]       word_count;
    } t_out_req;

    typedef struct packed {
        logic [7:0]  y;
        logic [7:0]  u;
        logic [7:0]  v;
        logic [15:0] p555;
        logic [15:0] p565;
    } t_lane_res;

    typedef struct packed {
        logic advance;
        logic s1_valid;
    } t_pipe_ctl;

endpackage

>>> hw/rtl/rgb_to_overlay_pixel_pack.sv
// Top level of the overlay pixel-pair packer: format register, two pixel
// lanes and the merge stage. Depends on rop_pkg, rop_lane and rop_merge.
//
// Channel   Direction  Handshake            Payload
// in        input      i_in_valid/o_in_stall  i_in_data  (rop_pkg::t_in_req)
// out       output     o_out_valid/i_out_stall o_out_data (rop_pkg::t_out_req)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_data (output format)
//
// Each request passes two registered stages: the lanes register it at the accepting
// edge and the merge stage loads its result into the output register when the pipe
// next advances. One request is taken every cycle while the output is not stalled.
// The lanes and the output register advance together whenever the output
// register is empty or being taken; the input stalls only while a held result
// is stalled downstream. Reset clears the valid flags and sets pass32 format.
module rgb_to_overlay_pixel_pack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  rop_pkg::t_in_req          i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output rop_pkg::t_out_req         o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rop_pkg::FMT_W-1:0] i_cfg_data
);

    logic [rop_pkg::FMT_W-1:0] r_format;
    logic                      r_s1_valid;
    rop_pkg::t_in_req          r_raw;
    rop_pkg::t_lane_res        lane0_res;
    rop_pkg::t_lane_res        lane1_res;
    rop_pkg::t_pipe_ctl        ctl;
    logic                      advance;
    logic                      load;

    assign advance     = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !advance;
    assign load        = advance && i_in_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= rop_pkg::FMT_PASS32;
        end else if (i_cfg_valid) begin
            r_format <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_raw <= i_in_data;
        end
    end

    rop_lane u_lane0 (
        .i_clk   (i_clk),
        .i_en    (load),
        .i_pixel (i_in_data.first_pixel),
        .o_res   (lane0_res)
    );

    rop_lane u_lane1 (
        .i_clk   (i_clk),
        .i_en    (load),
        .i_pixel (i_in_data.second_pixel),
        .o_res   (lane1_res)
    );

    assign ctl.advance  = advance;
    assign ctl.s1_valid = r_s1_valid;

    rop_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_format (r_format),
        .i_lane0  (lane0_res),
        .i_lane1  (lane1_res),
        .i_raw    (r_raw),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data)
    );

endmodule

>>> hw/rtl/rop_lane.sv
// One pixel lane: converts a 0x00BBGGRR pixel to Y, U, V and to RGB555/565.
// Results are registered. Depends on rop_pkg.
module rop_lane (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [rop_pkg::PIX_W-1:0] i_pixel,
    output rop_pkg::t_lane_res       o_res
);

    logic [7:0]         red;
    logic [7:0]         grn;
    logic [7:0]         blu;
    logic [16:0]        y_sum;
    logic [15:0]        u_sum;
    logic [15:0]        v_sum;
    rop_pkg::t_lane_res n_res;
    rop_pkg::t_lane_res r_res;

    assign red = i_pixel[7:0];
    assign grn = i_pixel[15:8];
    assign blu = i_pixel[23:16];

    always_comb begin
        y_sum = rop_pkg::Y_R_COEF * {9'd0, red} + rop_pkg::Y_G_COEF * {9'd0, grn}
              + rop_pkg::Y_B_COEF * {9'd0, blu};
        u_sum = rop_pkg::CHROMA_OFS + rop_pkg::U_B_COEF * {8'd0, blu}
              - rop_pkg::U_R_COEF * {8'd0, red} - rop_pkg::U_G_COEF * {8'd0, grn};
        v_sum = rop_pkg::CHROMA_OFS + rop_pkg::V_R_COEF * {8'd0, red}
              - rop_pkg::V_G_COEF * {8'd0, grn} - rop_pkg::V_B_COEF * {8'd0, blu};
        n_res.y    = y_sum[16] ? 8'hFF : y_sum[15:8];
        n_res.u    = u_sum[15:8];
        n_res.v    = v_sum[15:8];
        n_res.p555 = {1'b0, red[7:3], grn[7:3], blu[7:3]};
        n_res.p565 = {red[7:3], grn[7:2], blu[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> hw/rtl/rop_merge.sv
// Merge stage: averages the chroma of both lanes and packs the result word
// (two words in pass32) for the selected format into the output register. Depends on rop_pkg.
module rop_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rop_pkg::t_pipe_ctl        i_ctl,
    input  logic [rop_pkg::FMT_W-1:0] i_format,
    input  rop_pkg::t_lane_res        i_lane0,
    input  rop_pkg::t_lane_res        i_lane1,
    input  rop_pkg::t_in_req          i_raw,
    output logic                      o_valid,
    output rop_pkg::t_out_req         o_data
);

    logic [8:0]        u_pair;
    logic [8:0]        v_pair;
    logic [7:0]        uc;
    logic [7:0]        vc;
    rop_pkg::t_out_req n_data;
    rop_pkg::t_out_req r_data;
    logic              r_valid;

    always_comb begin
        u_pair = {1'b0, i_lane0.u} + {1'b0, i_lane1.u};
        v_pair = {1'b0, i_lane0.v} + {1'b0, i_lane1.v};
        uc     = u_pair[8:1];
        vc     = v_pair[8:1];
        n_data.high_word  = '0;
        n_data.word_count = 2'd1;
        case (i_format)
            rop_pkg::FMT_PASS32: begin
                n_data.low_word   = i_raw.first_pixel;
                n_data.high_word  = i_raw.second_pixel;
                n_data.word_count = 2'd2;
            end
            rop_pkg::FMT_YUY2: begin
                n_data.low_word = {vc, i_lane1.y, uc, i_lane0.y};
            end
            rop_pkg::FMT_UYVY: begin
                n_data.low_word = {i_lane1.y, vc, i_lane0.y, uc};
            end
            rop_pkg::FMT_RGB555: begin
                n_data.low_word = {i_lane1.p555, i_lane0.p555};
            end
            default: begin
                n_data.low_word = {i_lane1.p565, i_lane0.p565};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= i_ctl.s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance && i_ctl.s1_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
